### src/dudc_pkg.sv
// Package for the debounced up/down digit counter.
// Holds the shared constants, the config struct and the button indexes; no dependencies.
`default_nettype none
package dudc_pkg;

  localparam int NumButtons = 3;
  localparam int TimerWidth = 16;
  localparam int DigitWidth = 4;
  localparam logic [DigitWidth-1:0] DigitMax = 4'd9;

  localparam int BtnReset = 0;
  localparam int BtnInc   = 1;
  localparam int BtnDec   = 2;

  localparam logic [1:0] RegHoldDelay    = 2'd0;
  localparam logic [1:0] RegRepeatPeriod = 2'd1;
  localparam logic [1:0] RegPressedLevel = 2'd2;

  localparam logic [TimerWidth-1:0] HoldDelayReset    = 16'd100;
  localparam logic [TimerWidth-1:0] RepeatPeriodReset = 16'd100;

  typedef struct packed {
    logic [TimerWidth-1:0] hold_delay;
    logic [TimerWidth-1:0] repeat_period;
    logic                  pressed_level;
  } dudc_cfg_t;

endpackage
`default_nettype wire

### src/debounced_updown_digit_counter.sv
// Debounced up/down digit counter: top level with config registers and output buffer.
// An accepted input beat's result is registered in the output or skid entry.
// Throughput: one item per cycle; the two-entry output buffer keeps input open while
// one result waits, and in_ready drops only when both entries are full.
// Reset (rst, synchronous): registers to defaults, digit 0, timers 0, history released.
// Depends on dudc_pkg, dudc_lane, dudc_merge.
`default_nettype none
module debounced_updown_digit_counter
  import dudc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [NumButtons-1:0] raw_levels,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DigitWidth-1:0]      digit,
  output logic [NumButtons-1:0]      press_events,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [TimerWidth-1:0] cfg_data
);

  dudc_cfg_t             cfg;
  logic                  accept;
  logic                  pop;
  logic [NumButtons-1:0] presses;
  logic [DigitWidth-1:0] digit_next;

  logic                  skid_valid;
  logic [DigitWidth-1:0] skid_digit;
  logic [NumButtons-1:0] skid_events;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_delay    <= HoldDelayReset;
      cfg.repeat_period <= RepeatPeriodReset;
      cfg.pressed_level <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegHoldDelay:    cfg.hold_delay    <= cfg_data;
        RegRepeatPeriod: cfg.repeat_period <= cfg_data;
        RegPressedLevel: cfg.pressed_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < NumButtons; b++) begin : g_lane
    dudc_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .step  (accept),
      .level (raw_levels[b]),
      .cfg   (cfg),
      .fire  (presses[b])
    );
  end

  dudc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .presses    (presses),
    .digit_next (digit_next)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        digit        <= skid_digit;
        press_events <= skid_events;
        skid_valid   <= accept;
        skid_digit   <= digit_next;
        skid_events  <= presses;
      end else begin
        out_valid    <= accept;
        digit        <= digit_next;
        press_events <= presses;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_valid    <= 1'b1;
        digit        <= digit_next;
        press_events <= presses;
      end else begin
        skid_valid  <= 1'b1;
        skid_digit  <= digit_next;
        skid_events <= presses;
      end
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit <= DigitMax)
    else $error("digit out of range");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    accept && out_valid && !out_ready |=> skid_valid)
    else $error("beat accepted under stall not held in skid");

  a_pop_drains_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop && !accept |=> !skid_valid && out_valid)
    else $error("skid entry not moved to output");

endmodule
`default_nettype wire

### src/dudc_lane.sv
// One button lane: three-sample debounce, press detect and hold/repeat timer.
// Depends on dudc_pkg.
`default_nettype none
module dudc_lane
  import dudc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire logic      level,
  input  wire dudc_cfg_t cfg,
  output logic           fire
);

  logic                  hist_old;
  logic                  hist_new;
  logic                  stable;
  logic [TimerWidth-1:0] timer;

  logic                  stable_next;
  logic [TimerWidth-1:0] timer_next;
  logic [TimerWidth-1:0] timer_dec;

  assign timer_dec = timer - 1'b1;

  always_comb begin
    stable_next = stable;
    timer_next  = timer;
    fire        = 1'b0;
    if (hist_old == level && hist_new == level) begin
      if (stable != level) begin
        stable_next = level;
        if (level == cfg.pressed_level) begin
          fire       = 1'b1;
          timer_next = cfg.hold_delay;
        end
      end else if (level == cfg.pressed_level) begin
        if (timer_dec == '0) begin
          fire       = 1'b1;
          timer_next = cfg.repeat_period;
        end else begin
          timer_next = timer_dec;
        end
      end
    end
  end

  // history resets to the released level of the default (active low) polarity
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_old <= 1'b1;
      hist_new <= 1'b1;
      stable   <= 1'b1;
      timer    <= '0;
    end else if (step) begin
      hist_old <= hist_new;
      hist_new <= level;
      stable   <= stable_next;
      timer    <= timer_next;
    end
  end

endmodule
`default_nettype wire

### src/dudc_merge.sv
// Merge stage: applies the lanes' presses in button order to the decimal digit.
// Depends on dudc_pkg.
`default_nettype none
module dudc_merge
  import dudc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [NumButtons-1:0] presses,
  output logic [DigitWidth-1:0]      digit_next
);

  logic [DigitWidth-1:0] count;

  always_comb begin
    digit_next = count;
    if (presses[BtnReset]) begin
      digit_next = '0;
    end
    if (presses[BtnInc]) begin
      digit_next = (digit_next >= DigitMax) ? '0 : digit_next + 1'b1;
    end
    if (presses[BtnDec]) begin
      digit_next = (digit_next == '0) ? DigitMax : digit_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      count <= digit_next;
    end
  end

endmodule
`default_nettype wire

### verif/dudc_checker.sv
// Scoreboard for the debounced up/down digit counter: follows config beats, predicts
// the digit and press mask of every tick, and compares result beats in order.
// Depends on dudc_pkg.
module dudc_checker
  import dudc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [NumButtons-1:0] raw_levels,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DigitWidth-1:0] digit,
  input  logic [NumButtons-1:0] press_events,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [TimerWidth-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [DigitWidth-1:0] digit;
    logic [NumButtons-1:0] presses;
  } tick_result_t;

  dudc_cfg_t             regs;
  logic [2:0]            history [NumButtons];
  logic [NumButtons-1:0] stable_lvl;
  logic [TimerWidth-1:0] hold_tmr [NumButtons];
  logic [DigitWidth-1:0] digit_q;
  tick_result_t          expected_ticks [$];
  tick_result_t          predicted;
  tick_result_t          want;
  int                    mismatches = 0;
  int                    result_idx = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("[%0t] dudc_checker: result %0d: %s", $time, result_idx, msg);
    end
    mismatches++;
  endtask

  task automatic reset_model();
    int b;
    regs.hold_delay = HoldDelayReset;
    regs.repeat_period = RepeatPeriodReset;
    regs.pressed_level = 1'b0;
    for (b = 0; b < NumButtons; b++) begin
      history[b] = 3'b111;
      hold_tmr[b] = '0;
    end
    stable_lvl = '1;
    digit_q = '0;
    expected_ticks.delete();
  endtask

  task automatic tick_counter(input logic [NumButtons-1:0] lv, output tick_result_t res);
    logic [NumButtons-1:0] fired;
    int b;
    fired = '0;
    for (b = 0; b < NumButtons; b++) begin
      history[b] = {history[b][1:0], lv[b]};
      if (history[b] == {3{lv[b]}}) begin
        if (stable_lvl[b] != lv[b]) begin
          stable_lvl[b] = lv[b];
          if (lv[b] == regs.pressed_level) begin
            fired[b] = 1'b1;
            hold_tmr[b] = regs.hold_delay;
          end
        end else if (lv[b] == regs.pressed_level) begin
          hold_tmr[b] = hold_tmr[b] - 1'b1;
          if (hold_tmr[b] == '0) begin
            fired[b] = 1'b1;
            hold_tmr[b] = regs.repeat_period;
          end
        end
        if (fired[b]) begin
          case (b)
            BtnReset: digit_q = '0;
            BtnInc:   digit_q = (digit_q >= DigitMax) ? '0 : digit_q + 1'b1;
            default:  digit_q = (digit_q == '0) ? DigitMax : digit_q - 1'b1;
          endcase
        end
      end
    end
    res.digit = digit_q;
    res.presses = fired;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegHoldDelay:    regs.hold_delay = cfg_data;
          RegRepeatPeriod: regs.repeat_period = cfg_data;
          RegPressedLevel: regs.pressed_level = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("unexpected beat digit=%0d presses=%b",
                                    digit, press_events));
        end else begin
          want = expected_ticks.pop_front();
          if (digit !== want.digit) begin
            report_mismatch($sformatf("digit %0d, expected %0d", digit, want.digit));
          end
          if (press_events !== want.presses) begin
            report_mismatch($sformatf("presses %b, expected %b",
                                      press_events, want.presses));
          end
        end
        result_idx++;
      end
      if (in_valid && in_ready) begin
        tick_counter(raw_levels, predicted);
        expected_ticks.push_back(predicted);
      end
    end
    fail_count <= mismatches;
    pending <= expected_ticks.size();
  end

endmodule

### verif/tb_debounced_updown_digit_counter.sv
// Testbench top for the debounced up/down digit counter: drives tick and config beats
// with random gaps and back-pressure, and gives the verdict.
// Depends on dudc_pkg, dudc_checker and the block itself.
module tb_debounced_updown_digit_counter;
  import dudc_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int CycleLimit = 100000;
  localparam int TicksPerPhase = 95;
  localparam int RandomPhases = 9;
  localparam int OpeningTicks = 21;
  // sent left to right, active-low buttons
  localparam logic [3*OpeningTicks-1:0] Opening = {
    3'd5, 3'd5, 3'd5, 3'd7, 3'd5, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd3, 3'd3, 3'd3, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd0, 3'd0, 3'd0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [NumButtons-1:0] raw_levels = '1;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DigitWidth-1:0] digit;
  logic [NumButtons-1:0] press_events;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = RegHoldDelay;
  logic [TimerWidth-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    idle_pct = 17;
  int                    cycle_count = 0;

  debounced_updown_digit_counter u_top (.*);

  dudc_checker u_check (.*);

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_debounced_updown_digit_counter NOT OK");
      $finish;
    end
  end

  task automatic send_tick(input logic [NumButtons-1:0] lv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_levels <= lv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TimerWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [TimerWidth-1:0] hold,
                               input logic [TimerWidth-1:0] period, input logic pol);
    logic [TimerWidth-1:0] noise;
    noise = TimerWidth'($urandom);
    drain_results();
    write_reg(RegHoldDelay, hold);
    write_reg(RegRepeatPeriod, period);
    write_reg(RegPressedLevel, {noise[TimerWidth-1:1], pol});
    if ($urandom_range(1) == 1) write_reg(RegSpare, noise);
  endtask

  // held levels with random run lengths, plus single-tick bounces
  task automatic random_ticks(input int n, input int max_run);
    logic [NumButtons-1:0] held;
    logic [NumButtons-1:0] lv;
    int run_left;
    int i;
    held = NumButtons'($urandom);
    run_left = 0;
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        held = NumButtons'($urandom);
        run_left = $urandom_range(1, max_run);
      end
      run_left--;
      lv = held;
      if ($urandom_range(99) < 8) lv[$urandom_range(NumButtons-1)] ^= 1'b1;
      send_tick(lv);
    end
  endtask

  initial begin
    int i;
    int p;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < OpeningTicks; i++) begin
      send_tick(Opening[3*(OpeningTicks-1-i) +: 3]);
    end
    // flip polarity with history kept, repeat every tick
    apply_setting(16'd1, 16'd1, 1'b1);
    write_reg(RegSpare, 16'hFFFF);
    for (i = 0; i < 6; i++) send_tick(3'b111);

    for (p = 0; p < RandomPhases; p++) begin
      case (p)
        0: apply_setting(16'd3, 16'd2, 1'b0);
        1: apply_setting(16'd1, 16'd1, 1'b1);
        2: apply_setting(16'd0, 16'd0, 1'b0);
        3: apply_setting(16'hFFFF, 16'hFFFF, 1'b1);
        4: apply_setting(16'd6, 16'd1, 1'b0);
        5: apply_setting(16'd1, 16'hFFFF, 1'b1);
        6: apply_setting(16'hFFFF, 16'd1, 1'b0);
        default: apply_setting(TimerWidth'($urandom_range(1, 8)),
                               TimerWidth'($urandom_range(1, 5)),
                               1'($urandom_range(1)));
      endcase
      idle_pct = (p == 1 || p == 2) ? 0 : 17;
      if (p == 4) begin
        random_ticks(45, 20);
        drain_results();
        random_ticks(TicksPerPhase - 45, 20);
      end else begin
        random_ticks(TicksPerPhase, 20);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("tb_debounced_updown_digit_counter OK");
    end else begin
      $display("tb_debounced_updown_digit_counter NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/dudc_pkg.sv
src/dudc_lane.sv
src/dudc_merge.sv
src/debounced_updown_digit_counter.sv
verif/dudc_checker.sv
verif/tb_debounced_updown_digit_counter.sv
